@@ hw/rtl/lscn_pkg.sv @@
// Shared types and constants for the line sensor calibrate/normalize block.
// Used by lscn_divider and line_sensor_calibrate_normalize_top.
// No dependencies.
package lscn_pkg;

   localparam int CHANNELS_DEF = 12;

   localparam int CMD_W    = 2;
   localparam int CHAN_W   = 4;
   localparam int RAW_W    = 10;
   localparam int CSR_IDX_W = 2;

   // Dividend: |avg - from| * 1000 stays below 2^21; divisor: |span| below 2^11
   localparam int NUM_W  = 21;
   localparam int SPAN_W = 11;

   localparam logic [RAW_W-1:0] RAW_MAX      = 10'd1023;
   localparam logic [RAW_W-1:0] FULL_SCALE   = 10'd1000;
   localparam logic [RAW_W-1:0] THRESH_RESET = 10'd700;
   localparam int               LOW_GUARD    = 50;
   localparam int               HIGH_GUARD   = 20;

   typedef enum logic [CMD_W-1:0] {
      CMD_MEASURE   = 2'd0,
      CMD_CALIBRATE = 2'd1,
      CMD_CLEAR     = 2'd2,
      CMD_UNUSED    = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET    = 2'd0,
      CSR_INVERT    = 2'd1,
      CSR_THRESHOLD = 2'd2,
      CSR_NONE      = 2'd3
   } csr_index_type;

endpackage

@@ hw/rtl/lscn_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lscn_pkg for NUM_W and SPAN_W.
module lscn_divider
   import lscn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  dividend,
   input  logic [SPAN_W-1:0] divisor,
   output logic              done,
   output logic [NUM_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(NUM_W);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [NUM_W-1:0]  dvd_ff;
   logic [SPAN_W-1:0] rem_ff;
   logic [SPAN_W-1:0] dvs_ff;

   logic [SPAN_W:0]   trial;
   logic [SPAN_W:0]   diff;
   logic              fits;

   assign trial = {rem_ff, dvd_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   // Quotient bits shift in behind the dividend bits
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
         dvd_ff <= {dvd_ff[NUM_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

@@ hw/rtl/line_sensor_calibrate_normalize_top.sv @@
// Line sensor calibrate/normalize: averaging, min/max calibration, linear mapping.
// Depends on lscn_pkg and lscn_divider.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------------------
//   req      | req_valid/req_stall | cmd, channel, sample_a..sample_d
//   rsp      | rsp_valid/rsp_stall | out_channel, level, on_line, span_fault
//   csr      | csr_valid/csr_ready | csr_index, csr_data (always ready)
//
// One transaction at a time; req_stall stays high until the result is loaded.
// Measure: accept, calc, multiply, the 21-step divider, finish, send; then back to idle for the next accept.
// Calibrate, clear, the unused command and a zero span go from calc straight to send; then back to idle.
// A stalled result holds in the output register; a new transaction is taken meanwhile.
// Reset sets every minimum to 1023, every maximum to 0, threshold to 700.
module line_sensor_calibrate_normalize_top
   import lscn_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [CHAN_W-1:0]    req_channel,
   input  logic [RAW_W-1:0]     req_sample_a,
   input  logic [RAW_W-1:0]     req_sample_b,
   input  logic [RAW_W-1:0]     req_sample_c,
   input  logic [RAW_W-1:0]     req_sample_d,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CHAN_W-1:0]    rsp_out_channel,
   output logic [RAW_W-1:0]     rsp_level,
   output logic                 rsp_on_line,
   output logic                 rsp_span_fault,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [RAW_W-1:0]     csr_data
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CALC_W = RAW_W + 2;
   localparam int PROD_W = 2 * CALC_W;
   localparam int Q_W = NUM_W + 2;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_CALC = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_FIN  = 6'b010000,
      ST_SEND = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Configuration
   logic [RAW_W-1:0] offset_ff;
   logic             invert_ff;
   logic [RAW_W-1:0] thresh_ff;

   // Calibration marks
   logic [RAW_W-1:0] low_mark_ff  [CHANNELS];
   logic [RAW_W-1:0] high_mark_ff [CHANNELS];

   // Transaction context
   cmd_type          cmd_ff;
   logic [CHAN_W-1:0] chan_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             chan_ok_ff;
   logic [RAW_W-1:0] avg_ff;
   logic [RAW_W-1:0] lo_ff;
   logic [RAW_W-1:0] hi_ff;

   logic signed [CALC_W-1:0] x_ff;
   logic [SPAN_W-1:0]        span_mag_ff;
   logic                     span_neg_ff;
   logic                     quo_neg_ff;

   logic [RAW_W-1:0] res_level_ff;
   logic             res_line_ff;
   logic             res_fault_ff;

   logic              rsp_valid_ff;
   logic [CHAN_W-1:0] rsp_chan_ff;
   logic [RAW_W-1:0]  rsp_level_ff;
   logic              rsp_line_ff;
   logic              rsp_fault_ff;

   logic req_take;
   logic out_free;

   logic [CALC_W-1:0] sum;
   logic [RAW_W-1:0]  avg;
   logic [IDX_W-1:0]  req_idx;
   logic              req_ok;

   logic signed [CALC_W-1:0] from_v;
   logic signed [CALC_W-1:0] to_v;
   logic signed [CALC_W-1:0] span_v;
   logic signed [CALC_W-1:0] x_v;
   logic [CALC_W-1:0]        span_abs;

   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] num;
   logic [PROD_W-1:0]        num_abs;

   logic [NUM_W-1:0]    quo;
   logic                div_start;
   logic                div_done;
   logic signed [Q_W-1:0] q_s;
   logic signed [Q_W-1:0] v_s;
   logic [RAW_W-1:0]    level_v;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // Rounded average of the four conversions
   assign sum = CALC_W'(req_sample_a) + CALC_W'(req_sample_b)
              + CALC_W'(req_sample_c) + CALC_W'(req_sample_d) + CALC_W'(2);
   assign avg = sum[CALC_W-1:2];

   assign req_idx = req_channel[IDX_W-1:0];
   assign req_ok  = req_channel < CHAN_W'(CHANNELS);

   // Mapping window and position inside it
   always_comb begin
      from_v = $signed({2'b00, lo_ff}) + $signed({{2{offset_ff[RAW_W-1]}}, offset_ff})
             + CALC_W'(LOW_GUARD);
      to_v   = $signed({2'b00, hi_ff}) - CALC_W'(HIGH_GUARD);
      span_v = to_v - from_v;
      x_v    = $signed({2'b00, avg_ff}) - from_v;
      span_abs = span_v[CALC_W-1] ? CALC_W'(-span_v) : CALC_W'(span_v);
   end

   always_comb begin
      prod    = PROD_W'(x_ff) * $signed(PROD_W'(FULL_SCALE));
      num     = invert_ff ? -prod : prod;
      num_abs = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
   end

   assign div_start = (state_ff == ST_MUL);

   lscn_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_abs[NUM_W-1:0]),
      .divisor  (span_mag_ff),
      .done     (div_done),
      .quotient (quo)
   );

   // Signed quotient, offset for inverted mapping, clamp to 0..full scale
   always_comb begin
      q_s = quo_neg_ff ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
      v_s = q_s + (invert_ff ? $signed(Q_W'(FULL_SCALE)) : $signed(Q_W'(0)));
      if (v_s[Q_W-1]) begin
         level_v = '0;
      end else if (v_s > $signed(Q_W'(FULL_SCALE))) begin
         level_v = FULL_SCALE;
      end else begin
         level_v = v_s[RAW_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_take) state_in = ST_CALC;
         ST_CALC: begin
            if (cmd_ff == CMD_MEASURE && span_v != '0) state_in = ST_MUL;
            else state_in = ST_SEND;
         end
         ST_MUL:  state_in = ST_DIV;
         ST_DIV:  if (div_done) state_in = ST_FIN;
         ST_FIN:  state_in = ST_SEND;
         ST_SEND: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         invert_ff <= 1'b0;
         thresh_ff <= THRESH_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OFFSET:    offset_ff <= csr_data;
            CSR_INVERT:    invert_ff <= csr_data[0];
            CSR_THRESHOLD: thresh_ff <= csr_data;
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            low_mark_ff[i]  <= RAW_MAX;
            high_mark_ff[i] <= '0;
         end
      end else if (state_ff == ST_CALC) begin
         if (cmd_ff == CMD_CLEAR) begin
            for (int i = 0; i < CHANNELS; i++) begin
               low_mark_ff[i]  <= RAW_MAX;
               high_mark_ff[i] <= '0;
            end
         end else if (cmd_ff == CMD_CALIBRATE && chan_ok_ff) begin
            if (avg_ff < lo_ff) low_mark_ff[idx_ff] <= avg_ff;
            if (avg_ff > hi_ff) high_mark_ff[idx_ff] <= avg_ff;
         end
      end
   end

   // Context capture and result formation
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff     <= cmd_type'(req_cmd);
         chan_ff    <= req_channel;
         idx_ff     <= req_idx;
         chan_ok_ff <= req_ok;
         avg_ff     <= avg;
         lo_ff      <= req_ok ? low_mark_ff[req_idx]  : RAW_MAX;
         hi_ff      <= req_ok ? high_mark_ff[req_idx] : '0;
      end
      if (state_ff == ST_CALC) begin
         x_ff         <= x_v;
         span_mag_ff  <= span_abs[SPAN_W-1:0];
         span_neg_ff  <= span_v[CALC_W-1];
         res_level_ff <= (cmd_ff == CMD_CALIBRATE) ? avg_ff : '0;
         res_line_ff  <= 1'b0;
         res_fault_ff <= (cmd_ff == CMD_MEASURE) && (span_v == '0);
      end
      if (state_ff == ST_MUL) begin
         quo_neg_ff <= num[PROD_W-1] ^ span_neg_ff;
      end
      if (state_ff == ST_FIN) begin
         res_level_ff <= level_v;
         res_line_ff  <= level_v > thresh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_SEND && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SEND && out_free) begin
         rsp_chan_ff  <= chan_ff;
         rsp_level_ff <= res_level_ff;
         rsp_line_ff  <= res_line_ff;
         rsp_fault_ff <= res_fault_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_chan_ff;
   assign rsp_level       = rsp_level_ff;
   assign rsp_on_line     = rsp_line_ff;
   assign rsp_span_fault  = rsp_fault_ff;

`ifndef SYNTH
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   a_take_to_calc: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_CALC)
      else $error("accepted transaction did not enter calculation");

   a_line_excludes_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_line_ff && rsp_fault_ff))
      else $error("on_line and span_fault both set");

   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN |=> res_level_ff <= FULL_SCALE)
      else $error("normalized level above full scale");
`endif

endmodule

@@ tb/tb_line_sensor_calibrate_normalize_top.sv @@
// Self-checking testbench for line_sensor_calibrate_normalize_top: a directed table,
// then random calibrate/measure/clear/unused scans under several register settings.
// Depends on lscn_pkg and the RTL of the block; each result is checked against its directed expectation or a predictor.
module tb_line_sensor_calibrate_normalize_top;
   import lscn_pkg::*;

   localparam int CHANNELS   = CHANNELS_DEF;
   localparam int SCALE      = int'(FULL_SCALE);
   localparam int CYCLE_CAP  = 400000;
   localparam int PHASES     = 6;
   localparam int PHASE_LEN  = 72;
   localparam int HOLD_LEN   = 300;

   typedef struct packed {
      cmd_type             cmd;
      logic [CHAN_W-1:0]   channel;
      logic [RAW_W-1:0]    sample_a;
      logic [RAW_W-1:0]    sample_b;
      logic [RAW_W-1:0]    sample_c;
      logic [RAW_W-1:0]    sample_d;
   } scan_item_type;

   typedef struct packed {
      logic [CHAN_W-1:0]   chan;
      logic [RAW_W-1:0]    level;
      logic                line;
      logic                fault;
   } sensor_reading_type;

   typedef struct packed {
      scan_item_type       item;
      logic                has_exp;
      sensor_reading_type  exp;
   } scan_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [CMD_W-1:0]     req_cmd = CMD_MEASURE;
   logic [CHAN_W-1:0]    req_channel = '0;
   logic [RAW_W-1:0]     req_sample_a = '0;
   logic [RAW_W-1:0]     req_sample_b = '0;
   logic [RAW_W-1:0]     req_sample_c = '0;
   logic [RAW_W-1:0]     req_sample_d = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [CHAN_W-1:0]    rsp_out_channel;
   logic [RAW_W-1:0]     rsp_level;
   logic                 rsp_on_line;
   logic                 rsp_span_fault;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_OFFSET;
   logic [RAW_W-1:0]     csr_data = '0;

   // predictor state
   int cal_min [CHANNELS];
   int cal_max [CHANNELS];
   int cfg_offset = 0;
   int cfg_invert = 0;
   int cfg_threshold = int'(THRESH_RESET);

   sensor_reading_type pending_readings[$];
   scan_row_type       directed_scans[$];
   int                 mismatches = 0;
   int                 cycles = 0;
   int                 burst_left = 4;
   bit                 hold_off_req = 1'b0;

   line_sensor_calibrate_normalize_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_channel     (req_channel),
      .req_sample_a    (req_sample_a),
      .req_sample_b    (req_sample_b),
      .req_sample_c    (req_sample_c),
      .req_sample_d    (req_sample_d),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_channel (rsp_out_channel),
      .rsp_level       (rsp_level),
      .rsp_on_line     (rsp_on_line),
      .rsp_span_fault  (rsp_span_fault),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles == CYCLE_CAP) begin
         $display("tb_line_sensor_calibrate_normalize_top: FAIL");
         $finish;
      end
   end

   function automatic void clear_calibration();
      for (int i = 0; i < CHANNELS; i++) begin
         cal_min[i] = int'(RAW_MAX);
         cal_max[i] = 0;
      end
   endfunction

   // Average, calibrate or normalize one scan; updates the min/max store.
   function automatic sensor_reading_type calc_reading(input scan_item_type it);
      int sum, avg, lo, hi, from_pt, span, x, v;
      bit in_range;
      sensor_reading_type r;
      sum = it.sample_a + it.sample_b + it.sample_c + it.sample_d;
      avg = (sum + 2) / 4;
      in_range = it.channel < CHANNELS;
      r = '{chan: it.channel, level: '0, line: 1'b0, fault: 1'b0};
      case (it.cmd)
         CMD_CALIBRATE: begin
            if (in_range) begin
               if (avg < cal_min[it.channel]) cal_min[it.channel] = avg;
               if (avg > cal_max[it.channel]) cal_max[it.channel] = avg;
            end
            r.level = RAW_W'(avg);
         end
         CMD_CLEAR: clear_calibration();
         CMD_MEASURE: begin
            lo = in_range ? cal_min[it.channel] : int'(RAW_MAX);
            hi = in_range ? cal_max[it.channel] : 0;
            from_pt = lo + cfg_offset + LOW_GUARD;
            span = (hi - HIGH_GUARD) - from_pt;
            if (span == 0) begin
               r.fault = 1'b1;
            end else begin
               x = avg - from_pt;
               if (cfg_invert != 0) v = (x * -SCALE) / span + SCALE;
               else v = (x * SCALE) / span;
               if (v < 0) v = 0;
               if (v > SCALE) v = SCALE;
               r.level = RAW_W'(v);
               r.line = v > cfg_threshold;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic scan_row_type scan_row(input cmd_type cmd, input int ch, input int a,
                                             input int b, input int c, input int d,
                                             input bit has_exp, input int lvl = 0,
                                             input bit line = 0, input bit fault = 0);
      scan_row_type row;
      row.item = '{cmd: cmd, channel: CHAN_W'(ch), sample_a: RAW_W'(a),
                   sample_b: RAW_W'(b), sample_c: RAW_W'(c), sample_d: RAW_W'(d)};
      row.has_exp = has_exp;
      row.exp = '{chan: CHAN_W'(ch), level: RAW_W'(lvl), line: line, fault: fault};
      return row;
   endfunction

   // Jitter a sample around a base, now and then fully random.
   function automatic logic [RAW_W-1:0] noisy(input int base);
      int s;
      if ($urandom_range(0, 9) == 0) return RAW_W'($urandom);
      s = base + int'($urandom_range(0, 30)) - 15;
      if (s < 0) s = 0;
      if (s > int'(RAW_MAX)) s = int'(RAW_MAX);
      return RAW_W'(s);
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [RAW_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_OFFSET:    cfg_offset = int'($signed(data));
         CSR_INVERT:    cfg_invert = int'(data[0]);
         CSR_THRESHOLD: cfg_threshold = int'(data);
         default: ;
      endcase
   endtask

   task automatic send_scan(input scan_item_type it, input bit has_exp,
                            input sensor_reading_type typed_exp);
      sensor_reading_type want;
      int gap;
      req_valid    <= 1'b1;
      req_cmd      <= it.cmd;
      req_channel  <= it.channel;
      req_sample_a <= it.sample_a;
      req_sample_b <= it.sample_b;
      req_sample_c <= it.sample_c;
      req_sample_d <= it.sample_d;
      do @(posedge clock); while (req_stall);
      want = calc_reading(it);
      pending_readings.push_back(has_exp ? typed_exp : want);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   // Receiver: random stall segments, plus one long hold-off on request.
   initial begin
      int seg_mode, seg_len;
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            @(posedge clock);
            rsp_stall <= 1'b1;
            repeat (HOLD_LEN) @(posedge clock);
         end else begin
            seg_mode = $urandom_range(0, 3);
            seg_len  = $urandom_range(10, 60);
            repeat (seg_len) begin
               @(posedge clock);
               case (seg_mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 3) == 0);
                  2: rsp_stall <= ($urandom_range(0, 3) != 0);
                  default: rsp_stall <= ~rsp_stall;
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      sensor_reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            $error("unexpected transaction on channel %0d", rsp_out_channel);
            mismatches++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_out_channel !== want.chan) begin
               $error("out_channel: expected %0d, got %0d", want.chan, rsp_out_channel);
               mismatches++;
            end
            if (rsp_level !== want.level) begin
               $error("level: expected %0d, got %0d", want.level, rsp_level);
               mismatches++;
            end
            if (rsp_on_line !== want.line) begin
               $error("on_line: expected %0d, got %0d", want.line, rsp_on_line);
               mismatches++;
            end
            if (rsp_span_fault !== want.fault) begin
               $error("span_fault: expected %0d, got %0d", want.fault, rsp_span_fault);
               mismatches++;
            end
         end
      end
   end

   initial begin
      scan_item_type it;
      scan_row_type row;
      logic [RAW_W-1:0] off_val, thr_val, inv_word;
      int active, base, pick;
      bit inv;

      clear_calibration();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed scans under reset register values.
      directed_scans.push_back(scan_row(CMD_MEASURE, 0, 0, 0, 0, 0, 0));
      directed_scans.push_back(scan_row(CMD_CALIBRATE, 0, 1023, 1023, 1023, 1023, 1, 1023));
      directed_scans.push_back(scan_row(CMD_CALIBRATE, 0, 0, 0, 0, 0, 1, 0));
      directed_scans.push_back(scan_row(CMD_MEASURE, 0, 1023, 1023, 1023, 1023, 1, 1000, 1));
      directed_scans.push_back(scan_row(CMD_MEASURE, 0, 0, 0, 0, 0, 1, 0));
      directed_scans.push_back(scan_row(CMD_MEASURE, 0, 500, 501, 502, 503, 0));
      directed_scans.push_back(scan_row(CMD_CALIBRATE, 1, 100, 100, 100, 100, 1, 100));
      directed_scans.push_back(scan_row(CMD_CALIBRATE, 1, 170, 170, 170, 170, 1, 170));
      // zero span: max - 20 lands exactly on min + 50
      directed_scans.push_back(scan_row(CMD_MEASURE, 1, 400, 400, 400, 400, 1, 0, 0, 1));
      directed_scans.push_back(scan_row(CMD_CALIBRATE, 11, 1, 1, 0, 0, 1, 1));
      directed_scans.push_back(scan_row(CMD_CALIBRATE, 11, 1, 0, 0, 0, 1, 0));
      directed_scans.push_back(scan_row(CMD_CALIBRATE, 11, 1023, 1023, 1023, 1022, 1, 1023));
      directed_scans.push_back(scan_row(CMD_MEASURE, 11, 0, 1023, 0, 1023, 0));
      // out-of-range channels: calibrate reports only, measure sees reset marks
      directed_scans.push_back(scan_row(CMD_CALIBRATE, 15, 1023, 1023, 1023, 1023, 1, 1023));
      directed_scans.push_back(scan_row(CMD_MEASURE, 12, 0, 0, 0, 0, 0));
      directed_scans.push_back(scan_row(CMD_MEASURE, 15, 'h2AA, 'h155, 'h2AA, 'h155, 0));
      directed_scans.push_back(scan_row(CMD_UNUSED, 5, 1023, 1023, 1023, 1023, 1, 0));
      directed_scans.push_back(scan_row(CMD_UNUSED, 0, 0, 0, 0, 0, 1, 0));
      directed_scans.push_back(scan_row(CMD_CLEAR, 7, 1023, 0, 1023, 0, 1, 0));
      directed_scans.push_back(scan_row(CMD_MEASURE, 0, 512, 512, 512, 512, 0));
      directed_scans.push_back(scan_row(CMD_MEASURE, 1, 400, 400, 400, 400, 0));
      foreach (directed_scans[i]) begin
         row = directed_scans[i];
         send_scan(row.item, row.has_exp, row.exp);
      end
      req_valid <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         case (p)
            0: begin off_val = 10'h200; inv = 1'b1; thr_val = 10'd0;    end
            1: begin off_val = 10'h1FF; inv = 1'b0; thr_val = 10'd1000; end
            2: begin off_val = 10'd0;   inv = 1'b1; thr_val = 10'd1023; end
            default: begin
               off_val = RAW_W'($urandom);
               inv = 1'($urandom_range(0, 1));
               thr_val = RAW_W'($urandom_range(0, 1023));
            end
         endcase
         inv_word = RAW_W'($urandom);
         inv_word[0] = inv;
         write_reg(CSR_OFFSET, off_val);
         write_reg(CSR_INVERT, inv_word);
         if (p == 1) write_reg(CSR_NONE, RAW_W'($urandom));
         write_reg(CSR_THRESHOLD, thr_val);
         csr_valid <= 1'b0;
         // hold the result side for a long stretch while scans keep coming
         if (p == 1) hold_off_req = 1'b1;

         active = $urandom_range(3, CHANNELS);
         for (int k = 0; k < PHASE_LEN; k++) begin
            pick = $urandom_range(0, 99);
            if (k == 0 && p != 3) it.cmd = CMD_CLEAR;
            else if (k < 16) it.cmd = (pick < 85) ? CMD_CALIBRATE : CMD_MEASURE;
            else if (pick < 62) it.cmd = CMD_MEASURE;
            else if (pick < 90) it.cmd = CMD_CALIBRATE;
            else if (pick < 98) it.cmd = CMD_UNUSED;
            else it.cmd = CMD_CLEAR;
            if ($urandom_range(0, 99) < 8) it.channel = CHAN_W'($urandom_range(CHANNELS, 15));
            else it.channel = CHAN_W'($urandom_range(0, active - 1));
            // calibrate on dark or bright surfaces, measure anywhere
            if (it.cmd == CMD_CALIBRATE)
               base = $urandom_range(0, 1) ? $urandom_range(0, 350) : $urandom_range(600, 1023);
            else
               base = $urandom_range(0, 1023);
            it.sample_a = noisy(base);
            it.sample_b = noisy(base);
            it.sample_c = noisy(base);
            it.sample_d = noisy(base);
            send_scan(it, 1'b0, '0);
         end
         req_valid <= 1'b0;
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_line_sensor_calibrate_normalize_top: PASS");
      end else begin
         $display("tb_line_sensor_calibrate_normalize_top: FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/lscn_pkg.sv
hw/rtl/lscn_divider.sv
hw/rtl/line_sensor_calibrate_normalize_top.sv
tb/tb_line_sensor_calibrate_normalize_top.sv
